// File: src/psp_pkg.sv
package psp_pkg;

    localparam int QUBITS      = 32;
    localparam int COEFF_WIDTH = 16;
    localparam int FRAC_BITS   = COEFF_WIDTH - 2;
    localparam int PROD_WIDTH  = 2 * COEFF_WIDTH;
    // two products, one negated, plus rounding offset: two guard bits
    localparam int SUM_WIDTH   = 2 * COEFF_WIDTH + 2;
    localparam int NUM_LANES   = 4;

    typedef logic [QUBITS-1:0]             qbits_t;
    typedef logic signed [COEFF_WIDTH-1:0] coeff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;

    // product is scaled by (-i)^k
    typedef enum logic [1:0] {
        PHASE_ONE       = 2'd0,
        PHASE_MINUS_I   = 2'd1,
        PHASE_MINUS_ONE = 2'd2,
        PHASE_I         = 2'd3
    } phase_t;

    localparam sum_t ROUND_HALF = sum_t'(1) <<< (FRAC_BITS - 1);
    localparam sum_t COEFF_MAX  = sum_t'((64'sd1 <<< (COEFF_WIDTH - 1)) - 64'sd1);
    localparam sum_t COEFF_MIN  = sum_t'(-(64'sd1 <<< (COEFF_WIDTH - 1)));

    typedef struct packed {
        qbits_t left_xbits;
        qbits_t left_zbits;
        coeff_t left_real;
        coeff_t left_imag;
        qbits_t right_xbits;
        qbits_t right_zbits;
        coeff_t right_real;
        coeff_t right_imag;
    } operand_t;

    typedef struct packed {
        qbits_t      product_xbits;
        qbits_t      product_zbits;
        logic [1:0]  phase_code;
        coeff_t      product_real;
        coeff_t      product_imag;
        logic        saturated_flag;
    } result_t;

    typedef struct packed {
        prod_t ac;
        prod_t bd;
        prod_t ad;
        prod_t bc;
    } prods_t;

    // merge stage output: product string, phase and unrounded rotated parts
    typedef struct packed {
        qbits_t xbits;
        qbits_t zbits;
        phase_t phase;
        sum_t   re_sum;
        sum_t   im_sum;
    } merged_t;

endpackage

// File: src/psp_lane.sv
module psp_lane #(
    parameter int LANE_QUBITS = 8
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [LANE_QUBITS-1:0] lx,
    input  logic [LANE_QUBITS-1:0] lz,
    input  logic [LANE_QUBITS-1:0] rx,
    input  logic [LANE_QUBITS-1:0] rz,
    output logic [LANE_QUBITS-1:0] px,
    output logic [LANE_QUBITS-1:0] pz,
    output logic [1:0]             phase
);

    logic [LANE_QUBITS-1:0] px_reg, px_next;
    logic [LANE_QUBITS-1:0] pz_reg, pz_next;
    logic [1:0]             phase_reg, phase_next;
    logic [1:0]             cross_count;

    // population count mod 4
    function automatic logic [1:0] count_mod4(input logic [LANE_QUBITS-1:0] v);
        logic [1:0] acc;
        acc = '0;
        for (int i = 0; i < LANE_QUBITS; i++)
        begin
            acc = acc + 2'(v[i]);
        end
        return acc;
    endfunction

    always_comb
    begin
        px_next     = lx ^ rx;
        pz_next     = lz ^ rz;
        cross_count = count_mod4(lx & rz);
        // Y(left) + Y(right) + 2*(left X & right Z) - Y(product), mod 4
        phase_next  = count_mod4(lx & lz) + count_mod4(rx & rz)
                    + {cross_count[0], 1'b0}
                    - count_mod4(px_next & pz_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg    <= px_next;
            pz_reg    <= pz_next;
            phase_reg <= phase_next;
        end
    end

    assign px    = px_reg;
    assign pz    = pz_reg;
    assign phase = phase_reg;

endmodule

// File: src/psp_mult.sv
module psp_mult (
    input  logic            clk,
    input  logic            en,
    input  psp_pkg::coeff_t a,
    input  psp_pkg::coeff_t b,
    input  psp_pkg::coeff_t c,
    input  psp_pkg::coeff_t d,
    output psp_pkg::prods_t prods
);

    psp_pkg::prods_t prods_reg, prods_next;

    // operands sign-extended first so the product keeps all its bits
    always_comb
    begin
        prods_next.ac = psp_pkg::prod_t'(a) * psp_pkg::prod_t'(c);
        prods_next.bd = psp_pkg::prod_t'(b) * psp_pkg::prod_t'(d);
        prods_next.ad = psp_pkg::prod_t'(a) * psp_pkg::prod_t'(d);
        prods_next.bc = psp_pkg::prod_t'(b) * psp_pkg::prod_t'(c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prods_reg <= prods_next;
        end
    end

    assign prods = prods_reg;

endmodule

// File: src/psp_merge.sv
module psp_merge #(
    parameter int LANES       = 4,
    parameter int LANE_QUBITS = 8
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [LANES-1:0][LANE_QUBITS-1:0] lane_px,
    input  logic [LANES-1:0][LANE_QUBITS-1:0] lane_pz,
    input  logic [LANES-1:0][1:0]             lane_phase,
    input  psp_pkg::prods_t                   prods,
    output psp_pkg::merged_t                  merged
);

    psp_pkg::merged_t merged_reg, merged_next;

    logic [1:0]    phase_sum;
    psp_pkg::sum_t ac, bd, ad, bc;
    psp_pkg::sum_t r1, r2, i1, i2;

    always_comb
    begin
        phase_sum = '0;
        for (int l = 0; l < LANES; l++) begin
            phase_sum = phase_sum + lane_phase[l];
        end

        ac = psp_pkg::sum_t'(prods.ac);
        bd = psp_pkg::sum_t'(prods.bd);
        ad = psp_pkg::sum_t'(prods.ad);
        bc = psp_pkg::sum_t'(prods.bc);

        // unrotated: real = ac - bd, imag = ad + bc
        unique case (psp_pkg::phase_t'(phase_sum))
            psp_pkg::PHASE_ONE:
            begin
                r1 = ac;  r2 = -bd; i1 = ad;  i2 = bc;
            end
            psp_pkg::PHASE_MINUS_I:
            begin
                r1 = ad;  r2 = bc;  i1 = -ac; i2 = bd;
            end
            psp_pkg::PHASE_MINUS_ONE:
            begin
                r1 = -ac; r2 = bd;  i1 = -ad; i2 = -bc;
            end
            default:
            begin
                r1 = -ad; r2 = -bc; i1 = ac;  i2 = -bd;
            end
        endcase

        merged_next.xbits  = psp_pkg::qbits_t'(lane_px);
        merged_next.zbits  = psp_pkg::qbits_t'(lane_pz);
        merged_next.phase  = psp_pkg::phase_t'(phase_sum);
        // half-LSB offset folded in here; output stage only shifts and clips
        merged_next.re_sum = r1 + r2 + psp_pkg::ROUND_HALF;
        merged_next.im_sum = i1 + i2 + psp_pkg::ROUND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            merged_reg <= merged_next;
        end
    end

    assign merged = merged_reg;

endmodule

// File: src/pauli_string_product.sv
// Weighted Pauli string multiplier (binary symplectic form).
// operand channel: one transaction carries both strings (X and Z bit masks)
//   and their Q1.14 complex coefficients; accepted when operand_valid is high
//   and operand_stall is low.
// result channel: product string (XOR of operands), phase code k of (-i)^k,
//   rotated coefficient rounded to nearest (ties up) and saturated, plus a
//   flag when either part clipped. Delivered when result_valid is high and
//   result_stall is low.
// Pipeline: three register stages, lanes+multipliers, merge/add and the
//   output register. Throughput: one transaction per cycle while
//   result_stall is low. LANES lanes each count Y and crossing terms on a
//   slice of the qubits; the merge stage adds their phases mod 4.
// Reset (rst_n low, async) empties all stages; nothing is kept between
//   transactions. When the receiver stalls, the result register holds and
//   each stage holds once the one after it is full; bubbles are squeezed out,
//   so operand_stall rises only when all three stages hold data.
module pauli_string_product #(
    parameter int LANES = psp_pkg::NUM_LANES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              operand_valid,
    output logic              operand_stall,
    input  psp_pkg::operand_t operand,
    output logic              result_valid,
    input  logic              result_stall,
    output psp_pkg::result_t  result
);

    localparam int LANE_QUBITS = (psp_pkg::QUBITS + LANES - 1) / LANES;
    localparam int PAD_BITS    = LANES * LANE_QUBITS;

    // stage valids
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;

    // stage advance: a stage loads when it is empty or its successor loads
    logic out_ready, s2_ready, s1_ready;

    // qubit masks padded to a whole number of lanes (pad bits are zero)
    logic [PAD_BITS-1:0] lx_pad, lz_pad, rx_pad, rz_pad;

    logic [LANES-1:0][LANE_QUBITS-1:0] lane_px, lane_pz;
    logic [LANES-1:0][1:0]             lane_phase;

    psp_pkg::prods_t  prods;
    psp_pkg::merged_t merged;

    psp_pkg::result_t result_reg, result_next;
    psp_pkg::sum_t    re_q, im_q;
    logic             re_hi, re_lo, im_hi, im_lo;

    assign out_ready     = !out_valid_reg || !result_stall;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign operand_stall = !s1_ready;

    always_comb
    begin
        s1_valid_next  = s1_ready  ? operand_valid : s1_valid_reg;
        s2_valid_next  = s2_ready  ? s1_valid_reg  : s2_valid_reg;
        out_valid_next = out_ready ? s2_valid_reg  : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---- stage 1: per-lane phase counts and the four partial products ----
    assign lx_pad = PAD_BITS'(operand.left_xbits);
    assign lz_pad = PAD_BITS'(operand.left_zbits);
    assign rx_pad = PAD_BITS'(operand.right_xbits);
    assign rz_pad = PAD_BITS'(operand.right_zbits);

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        psp_lane #(
            .LANE_QUBITS (LANE_QUBITS)
        ) u_lane (
            .clk   (clk),
            .en    (s1_ready),
            .lx    (lx_pad[l*LANE_QUBITS +: LANE_QUBITS]),
            .lz    (lz_pad[l*LANE_QUBITS +: LANE_QUBITS]),
            .rx    (rx_pad[l*LANE_QUBITS +: LANE_QUBITS]),
            .rz    (rz_pad[l*LANE_QUBITS +: LANE_QUBITS]),
            .px    (lane_px[l]),
            .pz    (lane_pz[l]),
            .phase (lane_phase[l])
        );
    end

    psp_mult u_mult (
        .clk   (clk),
        .en    (s1_ready),
        .a     (operand.left_real),
        .b     (operand.left_imag),
        .c     (operand.right_real),
        .d     (operand.right_imag),
        .prods (prods)
    );

    // ---- stage 2: combine lane phases, rotate and sum the products ----
    psp_merge #(
        .LANES       (LANES),
        .LANE_QUBITS (LANE_QUBITS)
    ) u_merge (
        .clk        (clk),
        .en         (s2_ready),
        .lane_px    (lane_px),
        .lane_pz    (lane_pz),
        .lane_phase (lane_phase),
        .prods      (prods),
        .merged     (merged)
    );

    // ---- stage 3: drop fraction bits (offset already added) and clip ----
    always_comb
    begin
        re_q  = merged.re_sum >>> psp_pkg::FRAC_BITS;
        im_q  = merged.im_sum >>> psp_pkg::FRAC_BITS;
        re_hi = re_q > psp_pkg::COEFF_MAX;
        re_lo = re_q < psp_pkg::COEFF_MIN;
        im_hi = im_q > psp_pkg::COEFF_MAX;
        im_lo = im_q < psp_pkg::COEFF_MIN;

        result_next.product_xbits = merged.xbits;
        result_next.product_zbits = merged.zbits;
        result_next.phase_code    = merged.phase;

        if (re_hi)
            result_next.product_real = psp_pkg::coeff_t'(psp_pkg::COEFF_MAX);
        else if (re_lo)
            result_next.product_real = psp_pkg::coeff_t'(psp_pkg::COEFF_MIN);
        else
            result_next.product_real = psp_pkg::coeff_t'(re_q);

        if (im_hi)
            result_next.product_imag = psp_pkg::coeff_t'(psp_pkg::COEFF_MAX);
        else if (im_lo)
            result_next.product_imag = psp_pkg::coeff_t'(psp_pkg::COEFF_MIN);
        else
            result_next.product_imag = psp_pkg::coeff_t'(im_q);

        result_next.saturated_flag = re_hi || re_lo || im_hi || im_lo;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

endmodule

// File: tb/sv/pauli_string_product_checker.sv
`timescale 1ns / 100ps

module pauli_string_product_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              operand_valid,
    input  logic              operand_stall,
    input  psp_pkg::operand_t operand,
    input  logic              result_valid,
    input  logic              result_stall,
    input  psp_pkg::result_t  result,
    output int                errors,
    output int                pending
);

    localparam longint COEFF_HI = (longint'(1) <<< (psp_pkg::COEFF_WIDTH - 1)) - 1;
    localparam longint COEFF_LO = -(longint'(1) <<< (psp_pkg::COEFF_WIDTH - 1));

    psp_pkg::result_t expected_products[$];
    int               mismatch_count = 0;

    assign errors = mismatch_count;

    // nearest, ties toward +inf, then clip
    function automatic psp_pkg::coeff_t round_clip(input longint exact,
                                                   inout logic clipped);
        longint q;
        q = (exact + (longint'(1) <<< (psp_pkg::FRAC_BITS - 1))) >>> psp_pkg::FRAC_BITS;
        if (q > COEFF_HI)
        begin
            clipped = 1'b1;
            q = COEFF_HI;
        end
        else if (q < COEFF_LO)
        begin
            clipped = 1'b1;
            q = COEFF_LO;
        end
        return psp_pkg::coeff_t'(q);
    endfunction

    function automatic psp_pkg::result_t pauli_product_of(input psp_pkg::operand_t op);
        psp_pkg::result_t r;
        int               phase_sum;
        psp_pkg::phase_t  k;
        longint           a, b, c, d, ac, bd, ad, bc, re_exact, im_exact;
        logic             clipped;
        r.product_xbits = op.left_xbits ^ op.right_xbits;
        r.product_zbits = op.left_zbits ^ op.right_zbits;
        phase_sum = $countones(op.left_xbits & op.left_zbits)
                  + $countones(op.right_xbits & op.right_zbits)
                  + 2 * $countones(op.left_xbits & op.right_zbits)
                  - $countones(r.product_xbits & r.product_zbits);
        k = psp_pkg::phase_t'(phase_sum & 3);
        a = op.left_real;
        b = op.left_imag;
        c = op.right_real;
        d = op.right_imag;
        ac = a * c;
        bd = b * d;
        ad = a * d;
        bc = b * c;
        case (k)
            psp_pkg::PHASE_ONE:
            begin
                re_exact = ac - bd;
                im_exact = ad + bc;
            end
            psp_pkg::PHASE_MINUS_I:
            begin
                re_exact = ad + bc;
                im_exact = bd - ac;
            end
            psp_pkg::PHASE_MINUS_ONE:
            begin
                re_exact = bd - ac;
                im_exact = -(ad + bc);
            end
            default:
            begin
                re_exact = -(ad + bc);
                im_exact = ac - bd;
            end
        endcase
        clipped = 1'b0;
        r.product_real   = round_clip(re_exact, clipped);
        r.product_imag   = round_clip(im_exact, clipped);
        r.phase_code     = k;
        r.saturated_flag = clipped;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [63:0] want_v,
                                 input logic [63:0] got_v);
        if (mismatch_count < 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field,
                     want_v, got_v);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        psp_pkg::result_t want;
        if (!rst_n)
        begin
            expected_products.delete();
        end
        else
        begin
            if (operand_valid && !operand_stall)
                expected_products = {expected_products, pauli_product_of(operand)};
            if (result_valid && !result_stall)
            begin
                if (expected_products.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: result transaction with nothing expected: %h",
                                 $realtime, result);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_products.pop_front();
                    if (result.product_xbits !== want.product_xbits)
                        flag_mismatch("product_xbits", want.product_xbits,
                                      result.product_xbits);
                    if (result.product_zbits !== want.product_zbits)
                        flag_mismatch("product_zbits", want.product_zbits,
                                      result.product_zbits);
                    if (result.phase_code !== want.phase_code)
                        flag_mismatch("phase_code", want.phase_code, result.phase_code);
                    if (result.product_real !== want.product_real)
                        flag_mismatch("product_real", want.product_real,
                                      result.product_real);
                    if (result.product_imag !== want.product_imag)
                        flag_mismatch("product_imag", want.product_imag,
                                      result.product_imag);
                    if (result.saturated_flag !== want.saturated_flag)
                        flag_mismatch("saturated_flag", want.saturated_flag,
                                      result.saturated_flag);
                end
            end
        end
        pending = expected_products.size();
    end

endmodule

// File: tb/sv/pauli_string_product_tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the Pauli string multiplier. The checker beside
// the DUT predicts every result transaction; this module only feeds operand
// transactions, throttles the result side and decides pass/fail.
module pauli_string_product_tb;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 750;
    // longest natural quiet stretch is a long receiver hold plus a
    // long sender gap; the limit leaves a wide margin over that
    localparam int IDLE_LIMIT   = 2000;
    // pipeline is 3 deep; the drain wait at the end catches stray results
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 200;

    logic              clk;
    logic              rst_n;
    logic              operand_valid;
    logic              operand_stall;
    psp_pkg::operand_t operand;
    logic              result_valid;
    logic              result_stall;
    psp_pkg::result_t  result;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;
    int holds_requested = 0;
    int holds_served = 0;
    bit burst_mode = 1'b0;

    pauli_string_product dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operand       (operand),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    pauli_string_product_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .operand_valid (operand_valid),
        .operand_stall (operand_stall),
        .operand       (operand),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result),
        .errors        (mismatches),
        .pending       (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic psp_pkg::operand_t make_operand(
        input psp_pkg::qbits_t lx, input psp_pkg::qbits_t lz, input int lr, input int li,
        input psp_pkg::qbits_t rx, input psp_pkg::qbits_t rz, input int rr, input int ri);
        psp_pkg::operand_t op;
        op.left_xbits  = lx;
        op.left_zbits  = lz;
        op.left_real   = psp_pkg::coeff_t'(lr);
        op.left_imag   = psp_pkg::coeff_t'(li);
        op.right_xbits = rx;
        op.right_zbits = rz;
        op.right_real  = psp_pkg::coeff_t'(rr);
        op.right_imag  = psp_pkg::coeff_t'(ri);
        return op;
    endfunction

    // Coefficients lean on the rails and on tiny values so that clipping and
    // rounding ties show up often; the rest is uniform over all 16 bits.
    function automatic psp_pkg::coeff_t random_coeff();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: return psp_pkg::coeff_t'(16'h7FFF);
            1: return psp_pkg::coeff_t'(16'h8000);
            2: return psp_pkg::coeff_t'($urandom_range(0, 8) - 4);
            3: return psp_pkg::coeff_t'(16'h2000);   // 0.5, lands on half-LSB ties
            default: return psp_pkg::coeff_t'($urandom_range(0, 65535));
        endcase
    endfunction

    // Strings: mostly full random, some sparse (few qubits active), some
    // where both sides share X or Z masks so the XOR cancels.
    function automatic psp_pkg::qbits_t random_bits(input int style);
        case (style)
            0: return psp_pkg::qbits_t'($urandom & $urandom & $urandom);
            1: return '1;
            2: return '0;
            default: return psp_pkg::qbits_t'($urandom);
        endcase
    endfunction

    function automatic psp_pkg::operand_t random_operand();
        psp_pkg::operand_t op;
        int style;
        style = $urandom_range(0, 9);
        op.left_xbits  = random_bits(style < 2 ? 0 : (style == 9 ? $urandom_range(1, 2) : 3));
        op.left_zbits  = random_bits(style < 2 ? 0 : 3);
        op.right_xbits = random_bits(style < 2 ? 0 : 3);
        op.right_zbits = random_bits(style < 2 ? 0 : 3);
        if (style == 2)
            op.right_xbits = op.left_xbits;
        if (style == 3)
            op.right_zbits = op.left_zbits;
        op.left_real  = random_coeff();
        op.left_imag  = random_coeff();
        op.right_real = random_coeff();
        op.right_imag = random_coeff();
        return op;
    endfunction

    // Sender gap: none in burst stretches, otherwise mostly short, a few long.
    function automatic int pick_gap();
        int r;
        if (burst_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Called at a falling edge; returns at the falling edge after the
    // transaction is taken. valid stays high across back-to-back items, so
    // each step gets a single assignment to it.
    task automatic send_operand(input psp_pkg::operand_t op);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            operand_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        operand_valid <= 1'b1;
        operand       <= op;
        do
            @(posedge clk);
        while (operand_stall);
        @(negedge clk);
    endtask

    // Operand side: directed corner cases first, then the random stream.
    initial
    begin
        rst_n         = 1'b0;
        operand_valid = 1'b0;
        operand       = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // identity times identity, zero and unit coefficients
        send_operand(make_operand('0, '0, 0, 0, '0, '0, 0, 0));
        send_operand(make_operand('0, '0, 16384, 0, '0, '0, 16384, 0));
        // X*Z on one qubit gives -iY
        send_operand(make_operand(32'h1, '0, 16384, 0, '0, 32'h1, 16384, 0));
        // Z*X: phase sum goes negative and must wrap to 3
        send_operand(make_operand('0, 32'h1, 16384, 0, 32'h1, '0, 16384, 0));
        // Y*Y
        send_operand(make_operand(32'h1, 32'h1, 0, 16384, 32'h1, 32'h1, 0, 16384));
        // X*Z on two qubits: phase minus one
        send_operand(make_operand(32'h3, '0, 12345, -321, '0, 32'h3, -999, 7777));
        // top qubit only
        send_operand(make_operand(32'h8000_0000, '0, 100, 200, '0, 32'h8000_0000,
                                  300, -400));
        // all qubits Y on both sides, and all-ones against nothing
        send_operand(make_operand('1, '1, 5000, 6000, '1, '1, -7000, 8000));
        send_operand(make_operand('1, '1, -32768, 32767, '0, '0, 32767, -32768));
        send_operand(make_operand('1, '0, 1, -1, '0, '1, -1, 1));
        // real part clips high at phase one, low at phase minus one
        send_operand(make_operand('0, '0, -32768, 0, '0, '0, -32768, 0));
        send_operand(make_operand(32'h3, '0, -32768, 0, '0, 32'h3, -32768, 0));
        // imaginary part clips
        send_operand(make_operand('0, '0, -32768, -32768, '0, '0, -32768, -32768));
        send_operand(make_operand(32'h1, '0, 32767, 32767, '0, 32'h1, 32767, -32768));
        // exact half-LSB ties round toward plus infinity
        send_operand(make_operand('0, '0, 1, 0, '0, '0, 8192, 0));
        send_operand(make_operand('0, '0, -1, 0, '0, '0, 8192, 0));
        send_operand(make_operand('0, '0, 0, -3, '0, '0, 0, 8192));
        // rails against each other at phases one, minus i and i
        send_operand(make_operand('0, '0, 32767, -32768, '0, '0, -32768, 32767));
        send_operand(make_operand(32'h1, '0, 32767, -32768, '0, 32'h1, -32768, 32767));
        send_operand(make_operand('0, 32'h1, 32767, -32768, 32'h1, '0, -32768, 32767));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            // receiver holds off twice while the sender keeps pushing
            if (i == 120 || i == 520)
                holds_requested++;
            send_operand(random_operand());
        end
        operand_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("pauli_string_product_tb: done, clean");
        else
            $display("pauli_string_product_tb: done, errors");
        $finish;
    end

    // Result side: random stall runs, plus the long hold-offs on request.
    initial
    begin
        int   run_left;
        logic level;
        int   r;
        run_left     = 0;
        level        = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_requested > holds_served)
            begin
                holds_served++;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    level = ($urandom_range(0, 2) == 0);
                    r = $urandom_range(0, 99);
                    if (r < 80)
                        run_left = $urandom_range(1, 3);
                    else if (r < 97)
                        run_left = $urandom_range(4, 12);
                    else
                        run_left = $urandom_range(30, 80);
                end
                run_left--;
                result_stall <= level;
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge clk)
    begin
        if ((operand_valid && !operand_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("pauli_string_product_tb: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
